### hw/rtl/ifa_pkg.sv
// Package for the integer to ASCII field formatter.
// Holds field widths, ASCII codes, the queue entry type and the digit helpers.
// No dependencies.
`timescale 1ns / 1ps

package ifa_pkg;

   localparam int VALUE_W       = 64;
   localparam int OPT_W         = 6;
   localparam int CHAR_W        = 8;
   localparam int DIGIT_CNT     = 20;
   localparam int DIGIT_CNT_W   = $clog2(DIGIT_CNT + 1);
   localparam int DIGIT_IDX_W   = $clog2(DIGIT_CNT);
   localparam int BCD_W         = 4 * DIGIT_CNT;
   localparam int BITS_PER_STEP = 2;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
   localparam int WIDTH_LIMIT_MAX = 64;
   localparam int FIELD_CNT_W   = $clog2(WIDTH_LIMIT_MAX + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] DIGIT_BASE   = 8'd10;

   typedef struct packed {
      logic [BCD_W-1:0]       digits;
      logic [FIELD_CNT_W-1:0] nfill;
      logic [FIELD_CNT_W-1:0] nzero;
      logic [FIELD_CNT_W-1:0] total;
      logic                   upper;
      logic                   zfill;
   } ifa_entry_type;

   // One shift-add-3 step of binary to BCD conversion.
   function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic in_bit);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int i = 0; i < DIGIT_CNT; i++) begin
         if (bcd[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], in_bit};
   endfunction

   // Significant digit count, at least one.
   function automatic logic [DIGIT_CNT_W-1:0] count_digits(input logic [BCD_W-1:0] bcd);
      logic [DIGIT_CNT_W-1:0] n;
      n = DIGIT_CNT_W'(1);
      for (int i = 0; i < DIGIT_CNT; i++) begin
         if (bcd[i*4 +: 4] != 4'd0) begin
            n = DIGIT_CNT_W'(i + 1);
         end
      end
      return n;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else if (upper) begin
         c = CHAR_UPPER_A + CHAR_W'(d) - DIGIT_BASE;
      end else begin
         c = CHAR_LOWER_A + CHAR_W'(d) - DIGIT_BASE;
      end
      return c;
   endfunction

endpackage

### hw/rtl/ifa_if.sv
// Request and response channel interfaces of the field formatter.
// Depends on ifa_pkg for field widths.
`timescale 1ns / 1ps

interface ifa_req_if;
   logic                         valid;
   logic                         ready;
   logic [ifa_pkg::VALUE_W-1:0]  value;
   logic                         hex_mode;
   logic                         upper_case;
   logic                         zero_fill;
   logic [ifa_pkg::OPT_W-1:0]    min_width;
   logic [ifa_pkg::OPT_W-1:0]    precision;

   modport source(output valid, value, hex_mode, upper_case, zero_fill, min_width,
                  precision, input ready);
   modport sink(input valid, value, hex_mode, upper_case, zero_fill, min_width,
                precision, output ready);
endinterface

interface ifa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ifa_pkg::CHAR_W-1:0]  char_out;
   logic                        last_char;

   modport source(output valid, char_out, last_char, input ready);
   modport sink(input valid, char_out, last_char, output ready);
endinterface

### hw/rtl/ifa_front.sv
// Front end: accepts a request, converts the value to digits and sizes the field.
// Depends on ifa_pkg and ifa_req_if.
`timescale 1ns / 1ps

module ifa_front #(
   parameter int MAX_FIELD_WIDTH = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   ifa_req_if.sink               req,
   output ifa_pkg::ifa_entry_type push_entry,
   output logic                  push_valid,
   input  logic                  push_ready
);
   import ifa_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   localparam logic [FIELD_CNT_W-1:0] LIMIT = FIELD_CNT_W'(MAX_FIELD_WIDTH);

   front_state_type        state_ff, state_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [VALUE_W-1:0]     shift_ff, shift_in;
   logic [STEP_CNT_W-1:0]  step_ff, step_in;
   logic [FIELD_CNT_W-1:0] width_ff, width_in;
   logic [FIELD_CNT_W-1:0] prec_ff, prec_in;
   logic                   upper_ff, upper_in;
   logic                   zfill_ff, zfill_in;

   logic [FIELD_CNT_W-1:0] nd, body;

   assign req.ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);

   always_comb begin
      nd   = FIELD_CNT_W'(count_digits(bcd_ff));
      body = (prec_ff > nd) ? prec_ff : nd;
      push_entry.digits = bcd_ff;
      push_entry.nfill  = (width_ff > body) ? (width_ff - body) : '0;
      push_entry.nzero  = (prec_ff > nd) ? (prec_ff - nd) : '0;
      push_entry.total  = push_entry.nfill + push_entry.nzero + nd;
      push_entry.upper  = upper_ff;
      push_entry.zfill  = zfill_ff;
   end

   always_comb begin
      state_in = state_ff;
      bcd_in   = bcd_ff;
      shift_in = shift_ff;
      step_in  = step_ff;
      width_in = width_ff;
      prec_in  = prec_ff;
      upper_in = upper_ff;
      zfill_in = zfill_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               width_in = (int'(req.min_width) > MAX_FIELD_WIDTH) ? LIMIT
                          : FIELD_CNT_W'(req.min_width);
               prec_in  = (int'(req.precision) > MAX_FIELD_WIDTH) ? LIMIT
                          : FIELD_CNT_W'(req.precision);
               upper_in = req.upper_case;
               zfill_in = req.zero_fill;
               shift_in = req.value;
               step_in  = '0;
               if (req.hex_mode) begin
                  bcd_in   = BCD_W'(req.value);
                  state_in = F_PUSH;
               end else begin
                  bcd_in   = '0;
                  state_in = F_CONV;
               end
            end
         end
         F_CONV: begin
            bcd_in   = dabble_step(dabble_step(bcd_ff, shift_ff[VALUE_W-1]),
                                   shift_ff[VALUE_W-2]);
            shift_in = {shift_ff[VALUE_W-BITS_PER_STEP-1:0], BITS_PER_STEP'(0)};
            step_in  = step_ff + STEP_CNT_W'(1);
            if (step_ff == STEP_CNT_W'(CONV_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bcd_ff   <= bcd_in;
      shift_ff <= shift_in;
      step_ff  <= step_in;
      width_ff <= width_in;
      prec_ff  <= prec_in;
      upper_ff <= upper_in;
      zfill_ff <= zfill_in;
   end

   a_conv_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_CONV) && (step_ff == STEP_CNT_W'(CONV_STEPS - 1)) |=> state_ff == F_PUSH)
      else $error("conversion did not end after all steps");

   a_total_in_limit: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_entry.total <= LIMIT || push_entry.total <= FIELD_CNT_W'(DIGIT_CNT))
      else $error("field length exceeds limit");

endmodule

### hw/rtl/ifa_queue.sv
// Two-entry queue between the front end and the character emitter.
// Depends on ifa_pkg.
`timescale 1ns / 1ps

module ifa_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ifa_pkg::ifa_entry_type push_entry,
   input  logic                   push_valid,
   output logic                   push_ready,
   output ifa_pkg::ifa_entry_type head_entry,
   output logic                   head_valid,
   input  logic                   pop
);
   import ifa_pkg::*;

   ifa_entry_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

### hw/rtl/ifa_back.sv
// Back end: walks one queued field and emits a character per cycle while rsp.ready is high.
// Depends on ifa_pkg and ifa_rsp_if.
`timescale 1ns / 1ps

module ifa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ifa_pkg::ifa_entry_type head_entry,
   input  logic                   head_valid,
   output logic                   pop,
   ifa_rsp_if.source              rsp
);
   import ifa_pkg::*;

   logic [FIELD_CNT_W-1:0] pos_ff, pos_in;
   logic                   valid_ff, valid_in;
   logic [CHAR_W-1:0]      char_ff, char_in;
   logic                   last_ff, last_in;

   logic                   load;
   logic                   at_last;
   logic [FIELD_CNT_W-1:0] lead;
   logic [FIELD_CNT_W-1:0] dig_pos;
   logic [DIGIT_IDX_W-1:0] dig_idx;
   logic [CHAR_W-1:0]      next_char;

   assign rsp.valid     = valid_ff;
   assign rsp.char_out  = char_ff;
   assign rsp.last_char = last_ff;

   assign load    = head_valid && (!valid_ff || rsp.ready);
   assign at_last = (pos_ff == head_entry.total - FIELD_CNT_W'(1));
   assign pop     = load && at_last;

   always_comb begin
      lead    = head_entry.nfill + head_entry.nzero;
      dig_pos = head_entry.total - FIELD_CNT_W'(1) - pos_ff;
      dig_idx = dig_pos[DIGIT_IDX_W-1:0];
      priority if (pos_ff < head_entry.nfill) begin
         next_char = head_entry.zfill ? CHAR_ZERO : CHAR_SPACE;
      end else if (pos_ff < lead) begin
         next_char = CHAR_ZERO;
      end else begin
         next_char = digit_char(head_entry.digits[dig_idx*4 +: 4], head_entry.upper);
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = next_char;
         last_in  = at_last;
         pos_in   = at_last ? '0 : pos_ff + FIELD_CNT_W'(1);
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   a_pos_in_field: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> pos_ff < head_entry.total)
      else $error("character position beyond field");

   a_idle_pos_zero: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> pos_ff == '0)
      else $error("position not cleared between fields");

endmodule

### hw/rtl/integer_to_ascii_field_formatter.sv
// Top level of the integer to ASCII field formatter.
// Depends on ifa_pkg, ifa_if, ifa_front, ifa_queue and ifa_back.
//
// Usage:
//   req carries one unsigned 64-bit value with its options (hex_mode,
//   upper_case, zero_fill, min_width, precision). rsp returns the formatted
//   field one ASCII character per transfer, most significant first, with
//   last_char set on the final character. Width and precision above
//   MAX_FIELD_WIDTH saturate to it; a field is 1 character up to the larger
//   of MAX_FIELD_WIDTH and its digit count.
//   Flow: a hex request goes from acceptance straight to the push state, a
//   decimal one first through the two-bit-per-cycle BCD converter; the first
//   character of a queued field is then registered in the output register.
//   Throughput: the front end takes no new request until the last is queued;
//   the back end sends one character per cycle while rsp.ready is high, and
//   the two-entry queue lets the next request convert while characters go out.
//   Reset: synchronous, clears the queue, converter state and output valid flag;
//   no result is pending afterward.
//   Stall: when rsp.ready is low the output register holds its character,
//   the queue fills, and then req.ready drops until room frees up.
`timescale 1ns / 1ps

module integer_to_ascii_field_formatter #(
   parameter int MAX_FIELD_WIDTH = 40
) (
   input  logic      clock,
   input  logic      reset,
   ifa_req_if.sink   req,
   ifa_rsp_if.source rsp
);
   import ifa_pkg::*;

   ifa_entry_type push_entry;
   ifa_entry_type head_entry;
   logic          push_valid;
   logic          push_ready;
   logic          head_valid;
   logic          pop;

   ifa_front #(
      .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .push_entry(push_entry),
      .push_valid(push_valid),
      .push_ready(push_ready)
   );

   ifa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_entry(push_entry),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .head_entry(head_entry),
      .head_valid(head_valid),
      .pop       (pop)
   );

   ifa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_entry(head_entry),
      .head_valid(head_valid),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule
